// File: design/bba_pkg.sv
// Shared types and constants for the buddy allocator
// Depends on nothing; imported by every design file
package bba_pkg;

  // tree geometry
  localparam int MAX_DEPTH  = 10;
  localparam int NODE_W     = MAX_DEPTH;
  localparam int NODE_COUNT = (1 << MAX_DEPTH) - 1;
  localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
  localparam int CHUNK_W    = 17;
  localparam int ADDR_W     = 32;
  localparam int THR_W      = CHUNK_W + MAX_DEPTH - 1;
  localparam int CMP_W      = (THR_W > ADDR_W) ? THR_W : ADDR_W;
  localparam int PROD_W     = NODE_W + CHUNK_W;
  localparam int DIV_ITER   = ADDR_W;
  localparam int DCNT_W     = $clog2(DIV_ITER + 1);

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LEVELS = 2'd0;
  localparam logic [1:0] REG_CHUNK  = 2'd1;
  localparam logic [1:0] REG_POOL   = 2'd2;
  localparam logic [1:0] REG_BASE   = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LVL,
    ST_NODE_CHK,
    ST_ANC_CHK,
    ST_SIB_CHK,
    ST_MUL,
    ST_MARK,
    ST_DIV,
    ST_FREE_WR,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_DONE
  } state_t;

  // effective configuration
  typedef struct packed {
    logic [LVL_W-1:0]   levels;
    logic [CHUNK_W-1:0] chunk;
    logic [ADDR_W-1:0]  pool_size;
    logic [ADDR_W-1:0]  pool_base;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] addr;
    logic              we;
    logic              wdata;
  } mem_req_t;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [CHUNK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ADDR_W-1:0]  quotient;
    logic [CHUNK_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: design/buddy_allocator_bitmap_tree_top.sv
// Binary buddy allocator: configuration registers and unit wiring
// Depends on bba_pkg, bba_mem, bba_div and bba_ctrl
//
// Usage:
// - Request channel (in_valid / in_stall) carries operation, req_size and
//   block_address; a request is taken when in_valid is high and in_stall low.
// - Result channel (out_valid / out_stall) carries status and
//   granted_address, one result per request.
// - Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// - One request at a time through a single-port tree bitmap (one access
//   per cycle). Allocate: pick the level one threshold at a time, then
//   per candidate node check the node, each ancestor visited and a buddy,
//   then mark the ancestors one level at a time. Free: run the bit-serial
//   divider, then per level write the node, read its buddy and check it.
// - Reset: the bitmap is cleared, in_stall held high meanwhile.
// - A finished result waits in the output register while out_stall is
//   high; the next request is taken once that result has been loaded.
module buddy_allocator_bitmap_tree_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [bba_pkg::ADDR_W-1:0]  req_size,
  input  logic [bba_pkg::ADDR_W-1:0]  block_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [bba_pkg::ADDR_W-1:0]  granted_address,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_data
);
  import bba_pkg::*;

  logic [3:0]         levels_in_use;
  logic [CHUNK_W-1:0] leaf_chunk_size;
  logic [ADDR_W-1:0]  pool_size;
  logic [ADDR_W-1:0]  pool_base;

  cfg_t     cfg;
  mem_req_t mem_req;
  logic     mem_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use   <= 4'd10;
      leaf_chunk_size <= CHUNK_W'(64);
      pool_size       <= ADDR_W'(32768);
      pool_base       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVELS: levels_in_use   <= cfg_data[3:0];
        REG_CHUNK:  leaf_chunk_size <= cfg_data[CHUNK_W-1:0];
        REG_POOL:   pool_size       <= cfg_data;
        REG_BASE:   pool_base       <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective values: clamp level count, zero chunk counts as one
  always_comb begin
    if (levels_in_use == 4'd0) cfg.levels = LVL_W'(1);
    else if (32'(levels_in_use) > 32'(MAX_DEPTH)) cfg.levels = LVL_W'(MAX_DEPTH);
    else cfg.levels = LVL_W'(levels_in_use);
    cfg.chunk     = (leaf_chunk_size == '0) ? CHUNK_W'(1) : leaf_chunk_size;
    cfg.pool_size = pool_size;
    cfg.pool_base = pool_base;
  end

  bba_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .req_size        (req_size),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .granted_address (granted_address),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .div_req         (div_req),
    .div_rsp         (div_rsp)
  );

  bba_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bba_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// File: design/bba_mem.sv
// Single-port tree bitmap, one bit per node, registered read data
// Depends on bba_pkg
module bba_mem (
  input  logic              clk,
  input  bba_pkg::mem_req_t req,
  output logic              rdata
);
  import bba_pkg::*;

  logic bits [NODE_COUNT];

  // one write or one read per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      bits[req.addr] <= req.wdata;
    end
    rdata <= bits[req.addr];
  end

endmodule

// File: design/bba_div.sv
// Restoring divider, one quotient bit per cycle
// Depends on bba_pkg
module bba_div (
  input  logic              clk,
  input  logic              rst,
  input  bba_pkg::div_req_t req,
  output bba_pkg::div_rsp_t rsp
);
  import bba_pkg::*;

  logic [DCNT_W-1:0]  cnt;
  logic [ADDR_W-1:0]  quo;
  logic [CHUNK_W-1:0] rem;
  logic [CHUNK_W-1:0] dvs;
  logic [CHUNK_W:0]   partial;
  logic               ge;

  // trial subtract
  assign partial = {rem, quo[ADDR_W-1]};
  assign ge      = partial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= DCNT_W'(DIV_ITER);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      quo <= {quo[ADDR_W-2:0], ge};
      rem <= ge ? CHUNK_W'(partial - {1'b0, dvs}) : partial[CHUNK_W-1:0];
    end
  end

  assign rsp.done      = (cnt == '0);
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: design/bba_ctrl.sv
// Sequencer: level pick, node search, ancestor marking and merge walk
// Depends on bba_pkg; drives bba_mem and bba_div
module bba_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  bba_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [bba_pkg::ADDR_W-1:0]  req_size,
  input  logic [bba_pkg::ADDR_W-1:0]  block_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [bba_pkg::ADDR_W-1:0]  granted_address,
  output bba_pkg::mem_req_t           mem_req,
  input  logic                        mem_rdata,
  output bba_pkg::div_req_t           div_req,
  input  bba_pkg::div_rsp_t           div_rsp
);
  import bba_pkg::*;

  state_t state, state_next;

  logic [NODE_W-1:0] clr_idx, clr_idx_next;
  logic [LVL_W-1:0]  j, j_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [NODE_W-1:0] ofs, ofs_next;
  logic [NODE_W-1:0] node, node_next;
  logic [NODE_W-1:0] walk, walk_next;
  logic [PROD_W-1:0] prod, prod_next;
  logic [ADDR_W-1:0] size_q, size_q_next;
  logic [1:0]        res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  logic              out_valid_next;
  logic [1:0]        status_next;
  logic [ADDR_W-1:0] granted_next;

  logic              accept, out_free;
  logic [THR_W-1:0]  thr;
  logic              fits, lvl_last;
  logic [LVL_W-1:0]  level_sel;
  logic [NODE_W-1:0] first_sel, first_cur;
  logic [NODE_W-1:0] par_node, par_walk, par_par_walk, sib_walk, sib_node;
  logic [NODE_W-1:0] leaf_cnt, ofs_sh;
  logic [LVL_W-1:0]  sh;
  logic              nc_free, nc_walk, ac_taken, ac_top, sc_free;
  logic              found, advance, adv_end, div_bad;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // level pick: one threshold a cycle
  assign thr       = THR_W'(cfg.chunk) << j;
  assign fits      = CMP_W'(size_q) <= CMP_W'(thr);
  assign lvl_last  = (j == cfg.levels - 1'b1);
  assign level_sel = fits ? LVL_W'(cfg.levels - 1'b1 - j) : '0;
  assign first_sel = (NODE_W'(1) << level_sel) - 1'b1;
  assign first_cur = (NODE_W'(1) << level) - 1'b1;

  // tree navigation
  assign par_node     = (node - 1'b1) >> 1;
  assign par_walk     = (walk - 1'b1) >> 1;
  assign par_par_walk = (par_walk - 1'b1) >> 1;
  assign sib_walk     = walk[0] ? walk + 1'b1 : walk - 1'b1;
  assign sib_node     = node[0] ? node + 1'b1 : node - 1'b1;

  // search events
  assign nc_free  = (state == ST_NODE_CHK) && !mem_rdata && (node == '0);
  assign nc_walk  = (state == ST_NODE_CHK) && !mem_rdata && (node != '0);
  assign ac_taken = (state == ST_ANC_CHK) && mem_rdata;
  assign ac_top   = (state == ST_ANC_CHK) && !mem_rdata && (par_walk == '0);
  assign sc_free  = (state == ST_SIB_CHK) && mem_rdata;
  assign found    = nc_free || ac_top || sc_free;
  assign advance  = ((state == ST_NODE_CHK) && mem_rdata)
                 || ((state == ST_SIB_CHK) && !mem_rdata);
  assign adv_end  = advance && (ofs == first_cur);

  // block offset and free leaf range
  assign sh       = LVL_W'(cfg.levels - 1'b1 - level);
  assign ofs_sh   = ofs << sh;
  assign leaf_cnt = NODE_W'(1) << (cfg.levels - 1'b1);
  assign div_bad  = (div_rsp.remainder != '0)
                 || (div_rsp.quotient >= ADDR_W'(leaf_cnt));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_idx == NODE_W'(NODE_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_FREE) state_next = ST_DIV;
          else if (req_size > cfg.pool_size) state_next = ST_DONE;
          else state_next = ST_LVL;
        end
      end
      ST_LVL:      if (fits || lvl_last) state_next = ST_NODE_CHK;
      ST_NODE_CHK: begin
        if (found) state_next = ST_MUL;
        else if (nc_walk) state_next = ST_ANC_CHK;
        else if (adv_end) state_next = ST_DONE;
      end
      ST_ANC_CHK: begin
        if (ac_taken) state_next = ST_SIB_CHK;
        else if (ac_top) state_next = ST_MUL;
      end
      ST_SIB_CHK: begin
        if (found) state_next = ST_MUL;
        else if (adv_end) state_next = ST_DONE;
        else state_next = ST_NODE_CHK;
      end
      ST_MUL:      state_next = ST_MARK;
      ST_MARK:     if (node == '0) state_next = ST_DONE;
      ST_DIV: begin
        if (div_rsp.done) state_next = div_bad ? ST_DONE : ST_FREE_WR;
      end
      ST_FREE_WR:  state_next = (node == '0) ? ST_DONE : ST_FREE_RD;
      ST_FREE_RD:  state_next = ST_FREE_CHK;
      ST_FREE_CHK: state_next = mem_rdata ? ST_DONE : ST_FREE_WR;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath and memory/divider requests
  always_comb begin
    clr_idx_next    = clr_idx;
    j_next          = j;
    level_next      = level;
    ofs_next        = ofs;
    node_next       = node;
    walk_next       = walk;
    prod_next       = prod;
    size_q_next     = size_q;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    mem_req         = '{addr: node, we: 1'b0, wdata: 1'b0};
    div_req         = '{start: 1'b0, dividend: block_address - cfg.pool_base,
                        divisor: cfg.chunk};
    unique case (state)
      ST_CLEAR: begin
        mem_req      = '{addr: clr_idx, we: 1'b1, wdata: 1'b0};
        clr_idx_next = clr_idx + 1'b1;
      end
      ST_IDLE: begin
        size_q_next     = req_size;
        j_next          = '0;
        res_status_next = STAT_NOFIT;
        res_addr_next   = '0;
        if (accept && operation == OP_FREE) div_req.start = 1'b1;
      end
      ST_LVL: begin
        if (fits || lvl_last) begin
          level_next   = level_sel;
          ofs_next     = '0;
          node_next    = first_sel;
          mem_req.addr = first_sel;
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_NODE_CHK, ST_SIB_CHK: begin
        if (nc_walk) begin
          walk_next    = node;
          mem_req.addr = par_node;
        end else if (advance && !adv_end) begin
          ofs_next     = ofs + 1'b1;
          node_next    = node + 1'b1;
          mem_req.addr = node + 1'b1;
        end
      end
      ST_ANC_CHK: begin
        if (ac_taken) begin
          mem_req.addr = sib_walk;
        end else if (!ac_top) begin
          walk_next    = par_walk;
          mem_req.addr = par_par_walk;
        end
      end
      ST_MUL: prod_next = PROD_W'(ofs_sh) * PROD_W'(cfg.chunk);
      ST_MARK: begin
        mem_req = '{addr: node, we: 1'b1, wdata: 1'b1};
        if (node == '0) begin
          res_status_next = STAT_OK;
          res_addr_next   = cfg.pool_base + ADDR_W'(prod);
        end else begin
          node_next = par_node;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_status_next = div_bad ? STAT_BADADDR : STAT_OK;
          node_next       = leaf_cnt - 1'b1 + div_rsp.quotient[NODE_W-1:0];
        end
      end
      ST_FREE_WR:  mem_req = '{addr: node, we: 1'b1, wdata: 1'b0};
      ST_FREE_RD:  mem_req.addr = sib_node;
      ST_FREE_CHK: if (!mem_rdata) node_next = par_node;
      ST_DONE: ;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_next = out_valid;
    status_next    = status;
    granted_next   = granted_address;
    if (state == ST_DONE && out_free) begin
      out_valid_next = 1'b1;
      status_next    = res_status;
      granted_next   = res_addr;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j               <= j_next;
    level           <= level_next;
    ofs             <= ofs_next;
    node            <= node_next;
    walk            <= walk_next;
    prod            <= prod_next;
    size_q          <= size_q_next;
    res_status      <= res_status_next;
    res_addr        <= res_addr_next;
    status          <= status_next;
    granted_address <= granted_next;
  end

endmodule
